// ===== hw/rtl/chl_pkg.sv =====
package chl_pkg;

  // Field widths of the request and result items
  localparam int unsigned OP_W        = 2;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned WINDOW_BITS = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned SYM_W       = 8;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 16;

  // Largest count a single load can carry
  localparam int unsigned VALUE_MAX = 255;

  // Request kinds carried on the slave tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_COUNT  = 2'd0,
    OP_LOAD_SYMBOL = 2'd1,
    OP_QUERY       = 2'd2
  } op_e;

endpackage

// ===== hw/rtl/chl_ram.sv =====
module chl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/canonical_huffman_lookup_unit.sv =====
// Canonical Huffman decode table with window lookup.
// Slave stream: tuser selects the request kind (load count, load symbol,
// query); tdata carries index, value and the 16-bit bit window.
// Master stream: one result per query only; loads produce nothing.
// After a count load's write, a sweep walks the count registers once, one
// length a cycle, rebuilding the first-code and symbol-base tables.
// A query that hits passes through the lookup step, the parallel compare
// over all code lengths, which also issues the symbol memory read, and the
// read step, which takes the registered read data. A miss is presented from
// the lookup step. The block handles one request at a time and only returns
// to idle once the result is in the output register, so it takes no new
// request before it is through with the last one.
// A finished result sits in the output register; the next request is still
// accepted while it waits. If the receiver stalls, a following query waits
// in its lookup or read step until the output register is free.
// After reset all counts are zero (every query misses) and no sweep is
// needed; the symbol memory is not cleared and reads as unknown until loaded.
module canonical_huffman_lookup_unit #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [chl_pkg::S_TDATA_W-1:0]        s_axis_tdata,  // index, value, window
  input  logic [chl_pkg::OP_W-1:0]             s_axis_tuser,  // operation
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [chl_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // code_length, symbol, zero pad
  output logic [0:0]                           m_axis_tuser   // hit
);

  localparam int unsigned CLW = $clog2(MAX_CODE_LEN);
  localparam int unsigned FW  = MAX_CODE_LEN + 1;
  localparam int unsigned BW  = $clog2(MAX_CODE_LEN * chl_pkg::VALUE_MAX + 1);
  localparam int unsigned PW  = $clog2((MAX_CODE_LEN + 1) * chl_pkg::VALUE_MAX + 1);
  localparam int unsigned AW  = $clog2(SYMBOL_DEPTH);
  localparam int unsigned IW  = chl_pkg::INDEX_W;
  localparam int unsigned VW  = chl_pkg::VALUE_W;
  localparam int unsigned WB  = chl_pkg::WINDOW_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_LOOK,
    ST_READ
  } state_e;

  state_e state_q;

  // Request fields
  logic [IW-1:0] req_index;
  logic [VW-1:0] req_value;
  logic [WB-1:0] req_window;
  logic          s_accept;

  assign req_index  = s_axis_tdata[IW-1:0];
  assign req_value  = s_axis_tdata[IW+VW-1:IW];
  assign req_window = s_axis_tdata[IW+VW+WB-1:IW+VW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Request decode
  logic cnt_we;
  logic sym_we;
  logic is_query;

  always_comb begin
    cnt_we   = 1'b0;
    sym_we   = 1'b0;
    is_query = 1'b0;
    unique case (chl_pkg::op_e'(s_axis_tuser))
      chl_pkg::OP_LOAD_COUNT:
        cnt_we = s_accept && (req_index < IW'(MAX_CODE_LEN));
      chl_pkg::OP_LOAD_SYMBOL:
        sym_we = s_accept && ({1'b0, req_index} < (IW + 1)'(SYMBOL_DEPTH));
      chl_pkg::OP_QUERY:
        is_query = s_accept;
      default: ;
    endcase
  end

  // Count registers and derived first-code / symbol-base tables
  logic [VW-1:0]  counts_q  [MAX_CODE_LEN];
  logic [FW-1:0]  first_q   [MAX_CODE_LEN];
  logic [BW-1:0]  base_q    [MAX_CODE_LEN];
  logic [FW-1:0]  first_acc_q;
  logic [BW-1:0]  base_acc_q;
  logic [CLW-1:0] sweep_q;

  logic [FW:0]    first_sum;
  logic [FW+1:0]  first_dbl;
  logic [FW-1:0]  first_next;

  // Next first code, clamped: once out of range it can never match again
  assign first_sum  = {1'b0, first_acc_q} + (FW + 1)'(counts_q[sweep_q]);
  assign first_dbl  = {first_sum, 1'b0};
  assign first_next = (|first_dbl[FW+1:FW]) ? '1 : first_dbl[FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        counts_q[i] <= '0;
        first_q[i]  <= '0;
        base_q[i]   <= '0;
      end
      first_acc_q <= '0;
      base_acc_q  <= '0;
    end else if (cnt_we) begin
      counts_q[req_index[CLW-1:0]] <= req_value;
      first_acc_q <= '0;
      base_acc_q  <= '0;
    end else if (state_q == ST_SWEEP) begin
      first_q[sweep_q] <= first_acc_q;
      base_q[sweep_q]  <= base_acc_q;
      first_acc_q      <= first_next;
      base_acc_q       <= base_acc_q + BW'(counts_q[sweep_q]);
    end
  end

  // Query window
  logic [WB-1:0] window_q;

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      window_q <= req_window;
    end
  end

  // Parallel compare over all lengths, shortest match wins
  logic                     look_hit;
  logic [chl_pkg::LEN_W-1:0] look_len;
  logic [VW-1:0]            look_diff;
  logic [BW-1:0]            look_base;
  logic [PW-1:0]            look_pos;
  logic                     pos_ok;

  always_comb begin
    logic [FW-1:0] prefix;
    logic [FW-1:0] diff;
    look_hit  = 1'b0;
    look_len  = '0;
    look_diff = '0;
    look_base = '0;
    for (int l = MAX_CODE_LEN - 1; l >= 0; l--) begin
      prefix = FW'(window_q >> (WB - 1 - l));
      diff   = prefix - first_q[l];
      if ((prefix >= first_q[l]) && (diff < FW'(counts_q[l]))) begin
        look_hit  = 1'b1;
        look_len  = chl_pkg::LEN_W'(l + 1);
        look_diff = diff[VW-1:0];
        look_base = base_q[l];
      end
    end
  end

  assign look_pos = PW'(look_base) + PW'(look_diff);
  assign pos_ok   = look_hit && (look_pos < PW'(SYMBOL_DEPTH));

  // Symbol memory
  logic                      ram_re;
  logic [chl_pkg::SYM_W-1:0] ram_rdata;

  assign ram_re = (state_q == ST_LOOK) && pos_ok;

  chl_ram #(
    .WIDTH (chl_pkg::SYM_W),
    .DEPTH (SYMBOL_DEPTH)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (req_index[AW-1:0]),
    .wdata_i (req_value),
    .re_i    (ram_re),
    .raddr_i (look_pos[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer and output register
  logic                          m_valid_q;
  logic [chl_pkg::M_TDATA_W-1:0] m_data_q;
  logic                          m_hit_q;
  logic [chl_pkg::LEN_W-1:0]     len_q;
  logic                          out_free;
  logic                          out_load;

  assign out_free = !m_valid_q || m_axis_tready;
  // A result enters the output register this cycle
  assign out_load = out_free && (((state_q == ST_LOOK) && !pos_ok) || (state_q == ST_READ));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sweep_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_hit_q   <= 1'b0;
      len_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cnt_we) begin
            sweep_q <= '0;
            state_q <= ST_SWEEP;
          end else if (is_query) begin
            state_q <= ST_LOOK;
          end
        end
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == CLW'(MAX_CODE_LEN - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOOK: begin
          if (pos_ok) begin
            len_q   <= look_len;
            state_q <= ST_READ;
          end else if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= '0;
            m_hit_q   <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= chl_pkg::M_TDATA_W'({ram_rdata, len_q});
            m_hit_q   <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_hit_q;

`ifndef SYNTHESIS
  // A query always moves to the lookup step
  a_query_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |=> (state_q == ST_LOOK))
    else $error("query not followed by lookup");

  // A count load always starts a sweep from the shortest length
  a_count_to_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> ((state_q == ST_SWEEP) && (sweep_q == '0)))
    else $error("count load did not start a sweep");

  // Read data is delivered once the output register frees up
  a_read_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && out_free) |=> (m_axis_tvalid && m_axis_tuser[0]))
    else $error("symbol read not delivered");

  // A hit carries a non-zero length, a miss carries all zeros
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ? (m_axis_tdata[chl_pkg::LEN_W-1:0] != '0)
                                       : (m_axis_tdata == '0)))
    else $error("malformed result");

  // The symbol memory is never written and read in the same cycle
  a_ram_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sym_we && ram_re))
    else $error("symbol memory write collides with read");
`endif

endmodule
